@@ sv/rpg_pkg.sv @@
// Shared constants and helpers for the RGB ping-pong gradient unit.
package rpg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int ACC_W      = FRAC_BITS + CH_W + 1;
    localparam int DIV_W      = FRAC_BITS + CH_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int STEP_CNT_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = RGB_W;
    localparam int CH_IDX_W   = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_START_RGB  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_RGB    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_COUNT = 2'd2;

    localparam logic [CH_IDX_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_IDX_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_IDX_W-1:0] CH_BLUE  = 2'd2;

    typedef logic signed [ACC_W-1:0] acc_t;

    // Pick one 8-bit channel out of a packed RGB888 word.
    function automatic logic [CH_W-1:0] chan_of(input logic [RGB_W-1:0] rgb,
                                                input logic [CH_IDX_W-1:0] idx);
        logic [CH_W-1:0] c;
        unique case (idx)
            CH_RED:   c = rgb[3*CH_W-1:2*CH_W];
            CH_GREEN: c = rgb[2*CH_W-1:CH_W];
            default:  c = rgb[CH_W-1:0];
        endcase
        return c;
    endfunction

    // Integer part of an accumulator, negative clamps to zero.
    function automatic logic [CH_W-1:0] sat_chan(input acc_t acc);
        logic [CH_W-1:0] c;
        if (acc[ACC_W-1])
            c = '0;
        else
            c = acc[ACC_W-2:FRAC_BITS];
        return c;
    endfunction

endpackage

@@ sv/rgb_pingpong_gradient_unit.sv @@
// Top level of the RGB ping-pong gradient unit: sequencer, channel state, output register.
// Restart item: three divider passes (start, 24 quotient bits, step write), one per
// channel, plus accept and output load.
// Tick item: one shared add per channel plus accept and output load.
// One item at a time: the next item is taken in the cycle after the result loads;
// the output register lets it in while a result waits.
// Reset (rst_n, async low) clears accumulators, steps and tick count and loads
// the registers with their reset values.
module rgb_pingpong_gradient_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [rpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [rpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // [0] restart
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rpg_pkg::RGB_W-1:0]        m_axis_tdata,   // [23:0] rgb_out
    output logic [0:0]                       m_axis_tuser    // [0] turned
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_TICK,
        S_FIN
    } state_t;

    // configuration registers
    logic [rpg_pkg::RGB_W-1:0]        start_rgb_reg;
    logic [rpg_pkg::RGB_W-1:0]        end_rgb_reg;
    logic [rpg_pkg::STEP_CNT_W-1:0]   step_count_reg;

    // sequencer and channel state
    state_t                           state_reg;
    logic [rpg_pkg::CH_IDX_W-1:0]     ch_reg;
    rpg_pkg::acc_t                    acc_reg  [3];
    rpg_pkg::acc_t                    step_reg [3];
    logic [rpg_pkg::STEP_CNT_W-1:0]   tick_reg;
    logic                             turn_reg;

    // output register
    logic                             m_valid_reg;
    logic [rpg_pkg::RGB_W-1:0]        m_rgb_reg;
    logic                             m_turned_reg;

    logic                             in_fire;
    logic                             restart;
    logic [rpg_pkg::STEP_CNT_W-1:0]   tick_inc;
    logic                             turn_now;
    logic                             out_load;

    // divider hookup
    logic                             div_start;
    logic                             div_done;
    logic [rpg_pkg::DIV_W-1:0]        div_dividend;
    logic [rpg_pkg::DIV_W-1:0]        div_quotient;

    logic [rpg_pkg::CH_W:0]           ch_diff;      // end - start, 9-bit signed
    logic                             diff_neg;
    logic [rpg_pkg::CH_W-1:0]         diff_mag;
    rpg_pkg::acc_t                    quo_ext;
    rpg_pkg::acc_t                    step_new;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    assign tick_inc = tick_reg + 1'b1;
    assign turn_now = (tick_inc == step_count_reg);

    // result leaves the sequencer once the output slot is free or freeing
    assign out_load = (state_reg == S_FIN) && (!m_valid_reg || m_axis_tready);

    // |end - start| << FRAC_BITS is divided as a magnitude, sign put back after,
    // which truncates toward zero.
    assign ch_diff  = {1'b0, rpg_pkg::chan_of(end_rgb_reg, ch_reg)}
                    - {1'b0, rpg_pkg::chan_of(start_rgb_reg, ch_reg)};
    assign diff_neg = ch_diff[rpg_pkg::CH_W];
    assign diff_mag = diff_neg ? (~ch_diff[rpg_pkg::CH_W-1:0] + 1'b1)
                               : ch_diff[rpg_pkg::CH_W-1:0];
    assign div_dividend = {diff_mag, {rpg_pkg::FRAC_BITS{1'b0}}};
    assign div_start    = (state_reg == S_DIV_START);

    assign quo_ext = rpg_pkg::acc_t'({1'b0, div_quotient});

    always_comb
    begin
        if (step_count_reg == '0)
            step_new = '0;          // divide by zero yields a zero step
        else if (diff_neg)
            step_new = rpg_pkg::acc_t'(0) - quo_ext;
        else
            step_new = quo_ext;
    end

    rpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (step_count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_rgb_reg  <= '0;
            end_rgb_reg    <= '1;
            step_count_reg <= rpg_pkg::STEP_CNT_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rpg_pkg::REG_START_RGB:  start_rgb_reg  <= cfg_wdata;
                rpg_pkg::REG_END_RGB:    end_rgb_reg    <= cfg_wdata;
                rpg_pkg::REG_STEP_COUNT:
                    step_count_reg <= cfg_wdata[rpg_pkg::STEP_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, channel state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ch_reg       <= rpg_pkg::CH_RED;
            tick_reg     <= '0;
            turn_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
            m_rgb_reg    <= '0;
            m_turned_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i]  <= '0;
                step_reg[i] <= '0;
            end
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    ch_reg <= rpg_pkg::CH_RED;
                    if (in_fire)
                    begin
                        if (restart)
                        begin
                            // load start colour in 8.FRAC fixed point
                            for (int i = 0; i < 3; i++)
                                acc_reg[i] <= {1'b0,
                                    rpg_pkg::chan_of(start_rgb_reg,
                                                     rpg_pkg::CH_IDX_W'(i)),
                                    {rpg_pkg::FRAC_BITS{1'b0}}};
                            tick_reg  <= '0;
                            turn_reg  <= 1'b0;
                            state_reg <= S_DIV_START;
                        end
                        else
                        begin
                            tick_reg  <= turn_now ? '0 : tick_inc;
                            turn_reg  <= turn_now;
                            state_reg <= S_TICK;
                        end
                    end
                end

                S_DIV_START:
                    state_reg <= S_DIV_WAIT;

                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        step_reg[ch_reg] <= step_new;
                        if (ch_reg == rpg_pkg::CH_BLUE)
                            state_reg <= S_FIN;
                        else
                        begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end

                S_TICK:
                begin
                    // one channel per cycle through the shared adder
                    acc_reg[ch_reg] <= acc_reg[ch_reg] + step_reg[ch_reg];
                    if (turn_reg)
                        step_reg[ch_reg] <= rpg_pkg::acc_t'(0) - step_reg[ch_reg];
                    if (ch_reg == rpg_pkg::CH_BLUE)
                        state_reg <= S_FIN;
                    else
                        ch_reg <= ch_reg + 1'b1;
                end

                S_FIN:
                begin
                    // wait for a free output slot
                    if (out_load)
                    begin
                        m_rgb_reg    <= {rpg_pkg::sat_chan(acc_reg[0]),
                                         rpg_pkg::sat_chan(acc_reg[1]),
                                         rpg_pkg::sat_chan(acc_reg[2])};
                        m_turned_reg <= turn_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_rgb_reg;
    assign m_axis_tuser[0] = m_turned_reg;

endmodule

@@ sv/rpg_div.sv @@
// Serial restoring divider, one quotient bit per cycle.
module rpg_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [rpg_pkg::DIV_W-1:0]            dividend,
    input  logic [rpg_pkg::STEP_CNT_W-1:0]       divisor,
    output logic                                 done,
    output logic [rpg_pkg::DIV_W-1:0]            quotient
);

    logic [rpg_pkg::DIV_W-1:0]        quo_reg;
    logic [rpg_pkg::STEP_CNT_W-1:0]   rem_reg;
    logic [rpg_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [rpg_pkg::STEP_CNT_W:0]     trial;
    logic [rpg_pkg::STEP_CNT_W:0]     diff;
    logic                             fits;

    assign trial = {rem_reg, quo_reg[rpg_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rpg_pkg::DIV_CNT_W'(rpg_pkg::DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == rpg_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[rpg_pkg::DIV_W-2:0], fits};
            rem_reg <= fits ? diff[rpg_pkg::STEP_CNT_W-1:0]
                            : trial[rpg_pkg::STEP_CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ dv/rpg_color_checker.sv @@
// Checker for the RGB ping-pong gradient unit: predicts each color item and compares.
module rpg_color_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rpg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,    // [0] restart
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [rpg_pkg::RGB_W-1:0]      m_tdata,    // [23:0] rgb_out
    input  logic [0:0]                     m_tuser,    // [0] turned
    output int                             errors,
    output int                             pending
);

    typedef struct packed {
        logic [rpg_pkg::RGB_W-1:0] rgb;
        logic                      turned;
    } color_rec_t;

    // shadow copy of the registers
    logic [rpg_pkg::RGB_W-1:0]      start_rgb;
    logic [rpg_pkg::RGB_W-1:0]      end_rgb;
    logic [rpg_pkg::STEP_CNT_W-1:0] ticks_per_half;

    // shadow copy of the sweep state, 8.FRAC_BITS plus sign
    logic signed [rpg_pkg::ACC_W-1:0] level [3];
    logic signed [rpg_pkg::ACC_W-1:0] stride [3];
    logic [rpg_pkg::STEP_CNT_W-1:0]   tick_no;

    color_rec_t want_colors [$];
    int         errs;

    // integer part of a channel, clamped to 0..255
    function automatic logic [rpg_pkg::CH_W-1:0] channel_level(
        input logic signed [rpg_pkg::ACC_W-1:0] a);
        logic signed [rpg_pkg::ACC_W-1:0] whole;
        if (a < 0)
            return '0;
        whole = a >>> rpg_pkg::FRAC_BITS;
        if (whole > 255)
            return 8'hFF;
        return whole[rpg_pkg::CH_W-1:0];
    endfunction

    task automatic advance_sweep(input logic restart, output color_rec_t res);
        logic [rpg_pkg::CH_W-1:0] s_ch;
        logic [rpg_pkg::CH_W-1:0] e_ch;
        longint                   span;
        res.turned = 1'b0;
        if (restart)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s_ch = rpg_pkg::CH_W'(start_rgb >> (16 - 8 * i));
                e_ch = rpg_pkg::CH_W'(end_rgb >> (16 - 8 * i));
                span = (longint'(e_ch) - longint'(s_ch))
                     * (longint'(1) << rpg_pkg::FRAC_BITS);
                level[i] = rpg_pkg::ACC_W'(longint'(s_ch) << rpg_pkg::FRAC_BITS);
                // divide truncates toward zero; a zero count gives a zero step
                stride[i] = (ticks_per_half == '0) ? '0
                          : rpg_pkg::ACC_W'(span / longint'(ticks_per_half));
            end
            tick_no = '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                level[i] = level[i] + stride[i];
            tick_no = tick_no + 1'b1;
            if (tick_no == ticks_per_half)
            begin
                for (int i = 0; i < 3; i++)
                    stride[i] = -stride[i];
                tick_no = '0;
                res.turned = 1'b1;
            end
        end
        res.rgb = {channel_level(level[0]), channel_level(level[1]),
                   channel_level(level[2])};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        color_rec_t exp_c;
        color_rec_t got_c;
        if (!rst_n)
        begin
            start_rgb      = '0;
            end_rgb        = 24'hFFFFFF;
            ticks_per_half = 16'd64;
            for (int i = 0; i < 3; i++)
            begin
                level[i]  = '0;
                stride[i] = '0;
            end
            tick_no = '0;
            want_colors.delete();
            errs = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    rpg_pkg::REG_START_RGB:
                        start_rgb = cfg_wdata[rpg_pkg::RGB_W-1:0];
                    rpg_pkg::REG_END_RGB:
                        end_rgb = cfg_wdata[rpg_pkg::RGB_W-1:0];
                    rpg_pkg::REG_STEP_COUNT:
                        ticks_per_half = cfg_wdata[rpg_pkg::STEP_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                advance_sweep(s_tdata[0], exp_c);
                want_colors.push_back(exp_c);
            end
            if (m_tvalid && m_tready)
            begin
                got_c.rgb    = m_tdata;
                got_c.turned = m_tuser[0];
                if (want_colors.size() == 0)
                begin
                    if (errs < 10)
                        $display("unexpected color item: rgb %06h turned %0d",
                                 got_c.rgb, got_c.turned);
                    errs++;
                end
                else
                begin
                    exp_c = want_colors.pop_front();
                    if (got_c.rgb !== exp_c.rgb || got_c.turned !== exp_c.turned)
                    begin
                        if (errs < 10)
                            $display({"color mismatch: want rgb %06h turned %0d,",
                                      " got rgb %06h turned %0d"},
                                     exp_c.rgb, exp_c.turned, got_c.rgb, got_c.turned);
                        errs++;
                    end
                end
            end
            errors  <= errs;
            pending <= want_colors.size();
        end
    end

endmodule

@@ dv/tb_rgb_pingpong_gradient_unit.sv @@
// Testbench top for the RGB ping-pong gradient unit: stimulus, flow control and verdict.
module tb_rgb_pingpong_gradient_unit;

    // no register sits at this index; writes there must change nothing
    localparam logic [rpg_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
    localparam int SETTLE_CYCLES  = 4;     // quiet time before a register write
    localparam int LATENCY_CYCLES = 120;   // drain margin, longer than a restart item takes
    localparam int RANDOM_ITEMS   = 440;   // per idling phase, four phases

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we    = 1'b0;
    logic [rpg_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [rpg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [rpg_pkg::RGB_W-1:0] m_tdata;
    logic [0:0]                m_tuser;

    int errors;
    int pending;

    // idling odds in percent, set per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    // hold-off requests from stimulus, served by the receiver process
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int cycle_no = 0;

    always #1 clk = ~clk;

    rgb_pingpong_gradient_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    rpg_color_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending)
    );

    // Receiver: random stalls, or a long hold-off when stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_no++;
        if (cycle_no >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_no);
            $display("** rgb_pingpong_gradient_unit: FAILED **");
            $finish;
        end
    end

    // Offer one item and wait until it is taken. tvalid stays high on return,
    // so the caller must offer the next item or drop tvalid in the same step.
    task automatic offer_item(input logic restart);
        logic [7:0] d;
        d    = 8'($urandom);
        d[0] = restart;   // upper bits are don't-care noise
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic offer_ticks(input int n);
        for (int i = 0; i < n; i++)
            offer_item(1'b0);
    endtask

    // Stop offering, let every pending color item drain, then write all
    // registers back to back (plus the unused index with junk).
    task automatic load_sweep(input logic [rpg_pkg::RGB_W-1:0] c0,
                              input logic [rpg_pkg::RGB_W-1:0] c1,
                              input logic [rpg_pkg::STEP_CNT_W-1:0] cnt);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= rpg_pkg::REG_START_RGB;
        cfg_wdata <= c0;
        @(posedge clk);
        cfg_addr  <= rpg_pkg::REG_END_RGB;
        cfg_wdata <= c1;
        @(posedge clk);
        cfg_addr  <= rpg_pkg::REG_STEP_COUNT;
        cfg_wdata <= {8'($urandom), cnt};   // bits above the count are ignored
        @(posedge clk);
        cfg_addr  <= REG_UNUSED;
        cfg_wdata <= 24'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [rpg_pkg::RGB_W-1:0] pick_color();
        unique case ($urandom_range(5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [rpg_pkg::STEP_CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 16'($urandom_range(12, 1));
        if (r < 80)
            return 16'($urandom_range(200, 13));
        if (r < 88)
            return 16'd1;
        if (r < 93)
            return 16'hFFFF;
        if (r < 96)
            return 16'd0;
        return 16'($urandom);
    endfunction

    initial
    begin
        logic [rpg_pkg::RGB_W-1:0] ca;
        logic [rpg_pkg::RGB_W-1:0] cb;
        int                        sent;
        int                        n;
        int                        kind;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part, no idling ----------------
        // Out of reset the steps are zero, so ticks hold black.
        offer_ticks(2);
        // Reset registers: black to white over 64 ticks.
        offer_item(1'b1);
        offer_ticks(2);
        // Count of one: every tick turns; white down to black.
        load_sweep(24'hFFFFFF, 24'h000000, 16'd1);
        offer_item(1'b1);
        offer_ticks(3);
        // Count lowered below the tick counter without restart: no turn
        // until the counter wraps; then raised again so it turns at five.
        ca = 24'h102030;
        cb = 24'hF0E0D0;
        load_sweep(ca, cb, 16'd2);
        offer_item(1'b1);
        offer_ticks(1);
        load_sweep(ca, cb, 16'd1);
        offer_ticks(2);
        load_sweep(ca, cb, 16'd5);
        offer_ticks(2);
        // Full-range step, then a larger count: the accumulator runs past
        // 255 and wraps negative, so channels read zero.
        load_sweep(24'h000000, 24'hFFFFFF, 16'd1);
        offer_item(1'b1);
        load_sweep(24'h000000, 24'hFFFFFF, 16'd4);
        offer_ticks(2);
        // Same downward: accumulator goes below zero, channels clamp to zero.
        load_sweep(24'hFFFFFF, 24'h000000, 16'd1);
        offer_item(1'b1);
        load_sweep(24'hFFFFFF, 24'h000000, 16'd4);
        offer_ticks(2);
        // Largest count: tiny steps.
        load_sweep(24'h000000, 24'hFFFFFF, 16'hFFFF);
        offer_item(1'b1);
        offer_ticks(2);

        // Zero count: steps are zero, so the colour holds while the tick
        // counter runs on without a turn.
        load_sweep(24'h00FF80, 24'h804000, 16'd0);
        offer_item(1'b1);
        offer_ticks(3);

        // ---------------- random part, four idling phases ----------------
        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 73;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 73;
                end
                default:
                begin
                    src_idle_pct   = 7;
                    sink_stall_pct = 7;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS)
            begin
                load_sweep(pick_color(), pick_color(), pick_count());
                if (ph == 0 && sent == 0)
                begin
                    // receiver holds off while the sender keeps offering,
                    // so the unit fills up and stalls its input
                    hold_reqs++;
                    offer_item(1'b1);
                    offer_ticks(24);
                    sent += 25;
                end
                n    = $urandom_range(60, 5);
                kind = $urandom_range(99);
                if (kind < 80)
                begin
                    // well-formed sweep: restart, then a run of ticks
                    offer_item(1'b1);
                    offer_ticks(n);
                    sent += n + 1;
                end
                else if (kind < 90)
                begin
                    // new settings without restart: old steps, new count
                    offer_ticks(n);
                    sent += n;
                end
                else
                begin
                    // noise: restarts scattered among ticks
                    for (int i = 0; i < n; i++)
                        offer_item($urandom_range(3) == 0);
                    sent += n;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("** rgb_pingpong_gradient_unit: PASSED **");
        else
            $display("** rgb_pingpong_gradient_unit: FAILED **");
        $finish;
    end

endmodule
